@@ sv/rmth_pkg.sv @@
// Shared types and constants for the running median unit.
// Used by rmth_cell, rmth_chain and running_median_two_heaps_unit; no dependencies.
package rmth_pkg;

    localparam int HEAP_DEPTH = 1024;
    localparam int DATA_W     = 32;
    localparam int SIZE_W     = $clog2(HEAP_DEPTH) + 1;
    localparam int COUNT_W    = 11;
    localparam int SUM_W      = 48;

    typedef logic signed [DATA_W-1:0] rmth_data_t;
    typedef logic [SIZE_W-1:0]        rmth_size_t;
    typedef logic signed [SUM_W-1:0]  rmth_sum_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } rmth_op_t;

    typedef struct packed {
        rmth_op_t   op;
        logic       at_head;
        rmth_data_t key;
    } rmth_ctrl_t;

    localparam rmth_sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam rmth_sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

@@ sv/rmth_cell.sv @@
// One storage cell of a sorted chain: holds a value and its valid bit.
// Depends on rmth_pkg for the command struct and data type.
module rmth_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  rmth_pkg::rmth_ctrl_t ctrl,
    input  logic                is_max,
    input  rmth_pkg::rmth_data_t prev_data,
    input  logic                prev_valid,
    input  logic                prev_ahead,
    input  rmth_pkg::rmth_data_t next_data,
    input  logic                next_valid,
    output rmth_pkg::rmth_data_t data,
    output logic                valid,
    output logic                ahead
);

    rmth_pkg::rmth_data_t data_reg;
    rmth_pkg::rmth_data_t data_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 key_wins;

    // The incoming key belongs in front of this cell.
    assign key_wins = is_max ? ($signed(ctrl.key) > $signed(data_reg))
                             : ($signed(ctrl.key) < $signed(data_reg));
    assign ahead    = !valid_reg || ctrl.at_head || key_wins;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (ctrl.op)
            rmth_pkg::OP_INSERT:
            begin
                if (ahead && prev_ahead)
                begin
                    data_next  = prev_data;
                    valid_next = prev_valid;
                end
                else if (ahead)
                begin
                    data_next  = ctrl.key;
                    valid_next = 1'b1;
                end
            end
            rmth_pkg::OP_POP:
            begin
                data_next  = next_data;
                valid_next = next_valid;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

@@ sv/rmth_chain.sv @@
// A sorted chain of rmth_cell instances with its best value at the head.
// Depends on rmth_pkg and rmth_cell.
module rmth_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rmth_pkg::rmth_ctrl_t ctrl,
    input  logic                 is_max,
    output rmth_pkg::rmth_data_t head_data,
    output logic                 head_valid
);

    rmth_pkg::rmth_data_t data_w   [rmth_pkg::HEAP_DEPTH];
    logic                 valid_w  [rmth_pkg::HEAP_DEPTH];
    logic                 ahead_w  [rmth_pkg::HEAP_DEPTH];

    for (genvar i = 0; i < rmth_pkg::HEAP_DEPTH; i++)
    begin : g_cell
        rmth_pkg::rmth_data_t p_data;
        logic                 p_valid;
        logic                 p_ahead;
        rmth_pkg::rmth_data_t n_data;
        logic                 n_valid;

        if (i == 0)
        begin : g_first
            assign p_data  = '0;
            assign p_valid = 1'b0;
            assign p_ahead = 1'b0;
        end
        else
        begin : g_mid
            assign p_data  = data_w[i-1];
            assign p_valid = valid_w[i-1];
            assign p_ahead = ahead_w[i-1];
        end

        if (i == rmth_pkg::HEAP_DEPTH - 1)
        begin : g_last
            assign n_data  = '0;
            assign n_valid = 1'b0;
        end
        else
        begin : g_inner
            assign n_data  = data_w[i+1];
            assign n_valid = valid_w[i+1];
        end

        rmth_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .is_max      (is_max),
            .prev_data   (p_data),
            .prev_valid  (p_valid),
            .prev_ahead  (p_ahead),
            .next_data   (n_data),
            .next_valid  (n_valid),
            .data        (data_w[i]),
            .valid       (valid_w[i]),
            .ahead       (ahead_w[i])
        );
    end

    assign head_data  = data_w[0];
    assign head_valid = valid_w[0];

endmodule

@@ sv/running_median_two_heaps_unit.sv @@
// Running lower median over a stream of signed samples, kept in two sorted chains.
// Depends on rmth_pkg and rmth_chain.
// A request steps through accept, insert, rebalance and output; a rejected one skips
// insert and rebalance. A new request is taken only in the idle step, after the
// sequencer has left the output step; a waiting result holds the output step.
// Reset clears all sizes, valid bits and the running sum at once; no sweep.
module running_median_two_heaps_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [31:0]            sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            median,
    output logic [rmth_pkg::COUNT_W-1:0]  sample_count,
    output logic signed [47:0]            median_sum,
    output logic                          rejected
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_INS  = 4'b0010,
        ST_BAL  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    rmth_pkg::rmth_data_t sample_reg;
    rmth_pkg::rmth_data_t sample_next;
    logic                 rej_reg;
    logic                 rej_next;
    rmth_pkg::rmth_size_t lower_size_reg;
    rmth_pkg::rmth_size_t lower_size_next;
    rmth_pkg::rmth_size_t upper_size_reg;
    rmth_pkg::rmth_size_t upper_size_next;
    rmth_pkg::rmth_sum_t  sum_reg;
    rmth_pkg::rmth_sum_t  sum_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    rmth_pkg::rmth_data_t median_reg;
    rmth_pkg::rmth_data_t median_next;
    logic [rmth_pkg::COUNT_W-1:0] count_reg;
    logic [rmth_pkg::COUNT_W-1:0] count_next;
    rmth_pkg::rmth_sum_t  osum_reg;
    rmth_pkg::rmth_sum_t  osum_next;
    logic                 orej_reg;
    logic                 orej_next;

    rmth_pkg::rmth_ctrl_t lower_ctrl;
    rmth_pkg::rmth_ctrl_t upper_ctrl;
    rmth_pkg::rmth_data_t lower_head;
    logic                 lower_head_valid;
    rmth_pkg::rmth_data_t upper_head;
    logic                 upper_head_valid;

    logic [rmth_pkg::SIZE_W:0] lower_w;
    logic [rmth_pkg::SIZE_W:0] upper_w;
    logic [rmth_pkg::SIZE_W:0] total_w;
    rmth_pkg::rmth_data_t      cur_median;
    logic signed [rmth_pkg::SUM_W:0] sum_wide;
    rmth_pkg::rmth_sum_t       sum_sat;
    logic                      full;

    rmth_chain u_lower (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lower_ctrl),
        .is_max     (1'b1),
        .head_data  (lower_head),
        .head_valid (lower_head_valid)
    );

    rmth_chain u_upper (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (upper_ctrl),
        .is_max     (1'b0),
        .head_data  (upper_head),
        .head_valid (upper_head_valid)
    );

    assign lower_w    = {1'b0, lower_size_reg};
    assign upper_w    = {1'b0, upper_size_reg};
    assign total_w    = lower_w + upper_w;
    assign full       = (lower_w >= (rmth_pkg::SIZE_W+1)'(rmth_pkg::HEAP_DEPTH));
    assign cur_median = lower_head_valid ? lower_head : '0;
    assign sum_wide   = {sum_reg[rmth_pkg::SUM_W-1], sum_reg}
                      + {{(rmth_pkg::SUM_W+1-rmth_pkg::DATA_W){cur_median[rmth_pkg::DATA_W-1]}},
                         cur_median};
    assign sum_sat    = (sum_wide[rmth_pkg::SUM_W] != sum_wide[rmth_pkg::SUM_W-1])
                      ? (sum_wide[rmth_pkg::SUM_W] ? rmth_pkg::SUM_MIN : rmth_pkg::SUM_MAX)
                      : sum_wide[rmth_pkg::SUM_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        rej_next        = rej_reg;
        lower_size_next = lower_size_reg;
        upper_size_next = upper_size_reg;
        sum_next        = sum_reg;
        out_valid_next  = out_valid_reg;
        median_next     = median_reg;
        count_next      = count_reg;
        osum_next       = osum_reg;
        orej_next       = orej_reg;
        lower_ctrl      = '{op: rmth_pkg::OP_HOLD, at_head: 1'b0, key: '0};
        upper_ctrl      = '{op: rmth_pkg::OP_HOLD, at_head: 1'b0, key: '0};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample;
                    rej_next    = full;
                    state_next  = full ? ST_OUT : ST_INS;
                end
            end
            ST_INS:
            begin
                if (!lower_head_valid || $signed(sample_reg) <= $signed(lower_head))
                begin
                    lower_ctrl      = '{op: rmth_pkg::OP_INSERT, at_head: 1'b0, key: sample_reg};
                    lower_size_next = lower_size_reg + 1'b1;
                end
                else
                begin
                    upper_ctrl      = '{op: rmth_pkg::OP_INSERT, at_head: 1'b0, key: sample_reg};
                    upper_size_next = upper_size_reg + 1'b1;
                end
                state_next = ST_BAL;
            end
            ST_BAL:
            begin
                if (lower_w > upper_w + 1'b1)
                begin
                    lower_ctrl      = '{op: rmth_pkg::OP_POP, at_head: 1'b0, key: '0};
                    upper_ctrl      = '{op: rmth_pkg::OP_INSERT, at_head: 1'b1, key: lower_head};
                    lower_size_next = lower_size_reg - 1'b1;
                    upper_size_next = upper_size_reg + 1'b1;
                end
                else if (upper_w > lower_w)
                begin
                    upper_ctrl      = '{op: rmth_pkg::OP_POP, at_head: 1'b0, key: '0};
                    lower_ctrl      = '{op: rmth_pkg::OP_INSERT, at_head: 1'b1, key: upper_head};
                    upper_size_next = upper_size_reg - 1'b1;
                    lower_size_next = lower_size_reg + 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    median_next    = cur_median;
                    count_next     = total_w[rmth_pkg::COUNT_W-1:0];
                    orej_next      = rej_reg;
                    if (rej_reg)
                    begin
                        osum_next = sum_reg;
                    end
                    else
                    begin
                        sum_next  = sum_sat;
                        osum_next = sum_sat;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lower_size_reg <= '0;
            upper_size_reg <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lower_size_reg <= lower_size_next;
            upper_size_reg <= upper_size_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        rej_reg    <= rej_next;
        median_reg <= median_next;
        count_reg  <= count_next;
        osum_reg   <= osum_next;
        orej_reg   <= orej_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign median       = median_reg;
    assign sample_count = count_reg;
    assign median_sum   = osum_reg;
    assign rejected     = orej_reg;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for running_median_two_heaps_unit: directed and random sample requests
// are checked against a two-heap predictor of the lower median, count and running sum.
// Depends on rmth_pkg and running_median_two_heaps_unit.
module tb;
    import rmth_pkg::*;

    localparam int LOWER_SIDE        = 0;
    localparam int UPPER_SIDE        = 1;
    localparam int RANDOM_REQUESTS   = 600;
    localparam int HOLD_CYCLES       = 300;
    localparam int STALL_LIMIT       = 3000;
    localparam int TAIL_CYCLES       = 20;
    localparam int REPORT_LIMIT      = 10;

    typedef struct {
        rmth_data_t value;
        bit         drain;
    } sample_req_t;

    typedef struct {
        rmth_data_t         median;
        logic [COUNT_W-1:0] count;
        rmth_sum_t          total;
        logic               rejected;
    } median_report_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    rmth_data_t         sample    = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    rmth_data_t         median;
    logic [COUNT_W-1:0] sample_count;
    rmth_sum_t          median_sum;
    logic               rejected;

    sample_req_t    sample_backlog [$];
    median_report_t median_forecast [$];

    rmth_data_t heap_mem [2][HEAP_DEPTH];
    int         heap_len [2] = '{0, 0};
    rmth_sum_t  median_total = '0;

    int unsigned acc_cnt;
    int unsigned res_cnt;
    int unsigned send_wait;
    int unsigned recv_wait;
    int unsigned hold_left;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned rejections_seen = 0;
    logic        hold_off;
    logic        hold_done;

    running_median_two_heaps_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .median       (median),
        .sample_count (sample_count),
        .median_sum   (median_sum),
        .rejected     (rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit outranks(rmth_data_t a, rmth_data_t b, int side);
        return (side == LOWER_SIDE) ? (a > b) : (a < b);
    endfunction

    function automatic void heap_insert(int side, rmth_data_t key);
        int         i;
        int         p;
        rmth_data_t t;
        i = heap_len[side];
        heap_mem[side][i] = key;
        heap_len[side] = i + 1;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!outranks(heap_mem[side][i], heap_mem[side][p], side))
                break;
            t = heap_mem[side][i];
            heap_mem[side][i] = heap_mem[side][p];
            heap_mem[side][p] = t;
            i = p;
        end
    endfunction

    function automatic rmth_data_t heap_take_root(int side);
        int         n;
        int         i;
        int         l;
        int         r;
        int         best;
        rmth_data_t root;
        rmth_data_t t;
        root = heap_mem[side][0];
        n = heap_len[side] - 1;
        heap_mem[side][0] = heap_mem[side][n];
        heap_len[side] = n;
        i = 0;
        forever
        begin
            l = 2 * i + 1;
            r = l + 1;
            best = i;
            if (l < n && outranks(heap_mem[side][l], heap_mem[side][best], side))
                best = l;
            if (r < n && outranks(heap_mem[side][r], heap_mem[side][best], side))
                best = r;
            if (best == i)
                break;
            t = heap_mem[side][i];
            heap_mem[side][i] = heap_mem[side][best];
            heap_mem[side][best] = t;
            i = best;
        end
        return root;
    endfunction

    function automatic median_report_t advance_median(rmth_data_t s);
        median_report_t         rep;
        logic signed [SUM_W:0]  wide;
        rep.rejected = 1'b0;
        if (heap_len[LOWER_SIDE] >= HEAP_DEPTH)
            rep.rejected = 1'b1;
        else
        begin
            if (heap_len[LOWER_SIDE] == 0 || s <= heap_mem[LOWER_SIDE][0])
                heap_insert(LOWER_SIDE, s);
            else
                heap_insert(UPPER_SIDE, s);
            if (heap_len[LOWER_SIDE] > heap_len[UPPER_SIDE] + 1)
                heap_insert(UPPER_SIDE, heap_take_root(LOWER_SIDE));
            else if (heap_len[UPPER_SIDE] > heap_len[LOWER_SIDE])
                heap_insert(LOWER_SIDE, heap_take_root(UPPER_SIDE));
            wide = median_total + heap_mem[LOWER_SIDE][0];
            if (wide > SUM_MAX)
                median_total = SUM_MAX;
            else if (wide < SUM_MIN)
                median_total = SUM_MIN;
            else
                median_total = wide[SUM_W-1:0];
        end
        rep.median = (heap_len[LOWER_SIDE] > 0) ? heap_mem[LOWER_SIDE][0] : '0;
        rep.count  = COUNT_W'(heap_len[LOWER_SIDE] + heap_len[UPPER_SIDE]);
        rep.total  = median_total;
        return rep;
    endfunction

    function automatic rmth_data_t pick_sample(rmth_data_t last);
        rmth_data_t v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = rmth_data_t'($urandom_range(0, 40)) - 20;
            6:
            begin
                v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                v = v ^ rmth_data_t'($urandom_range(0, 1));
            end
            7:          v = last;
            8:          v = rmth_data_t'($urandom_range(0, 2000000)) - 1000000;
            default:    v = -rmth_data_t'($urandom_range(0, 32'h3FFF_FFFF));
        endcase
        return v;
    endfunction

    task automatic check_report();
        median_report_t want;
        if (res_cnt >= acc_cnt)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("Result with no request outstanding: median %0d count %0d sum %0d",
                         median, sample_count, median_sum);
            return;
        end
        want = median_forecast[res_cnt];
        if (median !== want.median || sample_count !== want.count ||
            median_sum !== want.total || rejected !== want.rejected)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("Result %0d: expected median %0d count %0d sum %0d rejected %0b, %s",
                         res_cnt, want.median, want.count, want.total, want.rejected,
                         $sformatf("got median %0d count %0d sum %0d rejected %0b",
                                   median, sample_count, median_sum, rejected));
        end
        if (rejected === 1'b1)
            rejections_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample    <= '0;
            acc_cnt   <= 0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                median_forecast.push_back(advance_median(sample));
                acc_cnt <= acc_cnt + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    in_valid  <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (sample_backlog.size() > 0 &&
                         !(sample_backlog[0].drain &&
                           res_cnt != acc_cnt + (in_valid && in_ready)))
                begin
                    in_valid  <= 1'b1;
                    sample    <= sample_backlog[0].value;
                    send_wait <= ((acc_cnt / 64) % 4 == 1) ? 0 : $urandom_range(0, 6);
                    void'(sample_backlog.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        int unsigned wait_next;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            res_cnt   <= 0;
            recv_wait <= 0;
        end
        else
        begin
            wait_next = recv_wait;
            if (out_valid && out_ready)
            begin
                check_report();
                res_cnt <= res_cnt + 1;
                wait_next = ((res_cnt / 80) % 4 == 2) ? 0 : $urandom_range(0, 6);
            end
            else if (wait_next > 0)
                wait_next = wait_next - 1;
            recv_wait <= wait_next;
            out_ready <= (wait_next == 0) && !hold_off;
        end
    end

    // The receiver refuses results for a long stretch once, so that the unit backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off  <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_off)
        begin
            if (hold_left == 0)
            begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end
            else
                hold_left <= hold_left - 1;
        end
        else if (!hold_done && res_cnt >= 150)
        begin
            hold_off  <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rmth_data_t opening [20];
        rmth_data_t last;
        int         n;

        opening = '{
            32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd1,
            32'sd7, 32'sd7, 32'sd7, 32'sd7, -32'sd7,
            -32'sd7, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001, 32'sh7FFF_FFFE,
            32'sh5555_5555, 32'shAAAA_AAAA, 32'sd0, 32'sd0, 32'sd3
        };
        last = '0;
        foreach (opening[k])
        begin
            sample_backlog.push_back('{opening[k], 1'b0});
            last = opening[k];
        end
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            last = pick_sample(last);
            sample_backlog.push_back('{last, n == RANDOM_REQUESTS / 2});
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (!(sample_backlog.size() == 0 && !in_valid && res_cnt == acc_cnt))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (res_cnt != acc_cnt)
            mismatches++;

        $display("Checked %0d sample requests with random gaps on both sides, %0d refused.",
                 acc_cnt, rejections_seen);
        $display("Final count %0d, final running sum %0d, with a long receiver hold-off.",
                 heap_len[LOWER_SIDE] + heap_len[UPPER_SIDE], median_total);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ running_median_two_heaps_unit.f @@
sv/rmth_pkg.sv
sv/rmth_cell.sv
sv/rmth_chain.sv
sv/running_median_two_heaps_unit.sv
bench/tb.sv
